[rtl/grl_pkg.sv]
package grl_pkg;

    // default datapath width of the reducer
    localparam int WIDTH_DEF = 32;

    // external field widths
    localparam int VALUE_W = 32;
    localparam int RES_W   = 32;

    // operations of the shared shift/add unit
    typedef enum logic {
        OP_DIV,
        OP_MUL
    } unit_op_t;

    // command from the sequencer to the shared unit
    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUC_SETUP,
        ST_EUC_TEST,
        ST_EUC_WAIT,
        ST_QUO_WAIT,
        ST_MUL_WAIT,
        ST_END,
        ST_RESULT
    } state_t;

endpackage

[rtl/grl_shift_unit.sv]
module grl_shift_unit
    import grl_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  unit_cmd_t        cmd,
    input  logic [WIDTH-1:0] op_a,     // dividend or multiplier
    input  logic [WIDTH-1:0] op_b,     // divisor or multiplicand
    output logic             done,
    output logic [WIDTH-1:0] res_hi,   // remainder or product high half
    output logic [WIDTH-1:0] res_lo    // quotient or product low half
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    count_reg, count_next;
    unit_op_t         op_reg;
    logic [WIDTH-1:0] hi_reg, lo_reg, b_reg;

    logic [WIDTH:0]   add_x, add_y;
    logic             add_cin;
    logic [WIDTH+1:0] sum;
    logic             carry;
    logic [WIDTH-1:0] hi_step, lo_step;

    // one adder serves both restoring division and shift-add multiply
    always_comb begin
        case (op_reg)
            OP_DIV: begin
                add_x   = {hi_reg, lo_reg[WIDTH-1]};
                add_y   = ~{1'b0, b_reg};
                add_cin = 1'b1;
            end
            OP_MUL: begin
                add_x   = {1'b0, hi_reg};
                add_y   = lo_reg[0] ? {1'b0, b_reg} : '0;
                add_cin = 1'b0;
            end
            default: begin
                add_x   = '0;
                add_y   = '0;
                add_cin = 1'b0;
            end
        endcase
        sum   = {1'b0, add_x} + {1'b0, add_y} + (WIDTH+2)'(add_cin);
        carry = sum[WIDTH+1];
        case (op_reg)
            OP_DIV: begin
                // no borrow means the trial subtract fits
                hi_step = carry ? sum[WIDTH-1:0] : add_x[WIDTH-1:0];
                lo_step = {lo_reg[WIDTH-2:0], carry};
            end
            OP_MUL: begin
                hi_step = sum[WIDTH:1];
                lo_step = {sum[0], lo_reg[WIDTH-1:1]};
            end
            default: begin
                hi_step = hi_reg;
                lo_step = lo_reg;
            end
        endcase
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        if (cmd.start) begin
            busy_next  = 1'b1;
            count_next = CW'(WIDTH - 1);
        end else if (busy_reg) begin
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
            hi_reg <= '0;
            lo_reg <= op_a;
            b_reg  <= op_b;
        end else if (busy_reg) begin
            hi_reg <= hi_step;
            lo_reg <= lo_step;
        end
    end

    assign done   = done_reg;
    assign res_hi = hi_reg;
    assign res_lo = lo_reg;

    // sequencer never restarts a running operation
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("unit started while busy");

    // done only follows a running operation
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");

    // an operation runs until its count is spent
    a_busy_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && count_reg != '0 && !cmd.start) |=> busy_reg)
        else $error("unit stopped early");

endmodule

[rtl/running_gcd_lcm_reducer.sv]
// running gcd / lcm reducer
//
// input stream: one signed value per word on s_tdata, s_tlast marks the final
// value of a list. the first value of a list seeds both the running gcd and the
// running lcm; every later value is folded in with euclid's remainder loop and
// with lcm = a / gcd(a, b) * b at WIDTH bits.
// result stream: one word per list; m_tdata carries gcd and lcm, m_tuser the
// zero-divisor and overflow flags.
//
// throughput: one value at a time, s_tready high only while the sequencer waits
// for a value. a first value only seeds the accumulators; a later one goes through
// two euclid runs, then the quotient and the product, and every remainder, the
// quotient and the product each take one pass through the shared shift/add unit;
// a zero gcd in the lcm step skips quotient and product.
// result: a later value with s_tlast goes through ST_END to ST_RESULT, a first
// one straight to ST_RESULT, which loads the registered result word once the
// output register is free.
// reset: accumulators and flags clear, the next value starts a new list, no
// result is pending. a stalled receiver holds the result in the output register;
// the next value is still taken, and only a second result waits for the first.
module running_gcd_lcm_reducer
    import grl_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // value
    input  logic                   s_tlast,   // last

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*RES_W-1:0]     m_tdata,   // gcd_out, lcm_out
    output logic [1:0]             m_tuser    // zero_divisor, overflowed
);

    state_t           state_reg, state_next;

    // running state
    logic [WIDTH-1:0] acc_gcd_reg, acc_gcd_next;
    logic [WIDTH-1:0] acc_lcm_reg, acc_lcm_next;
    logic             at_first_reg, at_first_next;
    logic             sticky_zd_reg, sticky_zd_next;
    logic             sticky_ovf_reg, sticky_ovf_next;

    // per-word working registers
    logic [WIDTH-1:0] v_reg, v_next;
    logic             last_reg, last_next;
    logic             phase_reg, phase_next;   // 0: gcd run, 1: lcm divisor run
    logic [WIDTH-1:0] ga_reg, ga_next;
    logic [WIDTH-1:0] gb_reg, gb_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_load;
    logic [RES_W-1:0] gcd_out_reg, lcm_out_reg;
    logic             zd_out_reg, ovf_out_reg;

    // shared unit
    unit_cmd_t        cmd;
    logic [WIDTH-1:0] op_a, op_b;
    logic             u_done;
    logic [WIDTH-1:0] u_hi, u_lo;

    // datapath helpers
    logic [WIDTH-1:0] v_in;
    logic [WIDTH-1:0] x_sel, a_p, b_p;
    logic [WIDTH-1:0] abs_lcm, abs_v;
    logic             prod_neg, prod_ovf;
    logic [WIDTH-1:0] limit, prod_res;

    grl_shift_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (u_done),
        .res_hi  (u_hi),
        .res_lo  (u_lo)
    );

    // value wrapped or sign-extended to the datapath width
    assign v_in = WIDTH'(signed'(s_tdata));

    // euclid operands: a negative operand takes the other one's value
    assign x_sel = phase_reg ? acc_lcm_reg : acc_gcd_reg;
    assign a_p   = x_sel[WIDTH-1] ? v_reg : x_sel;
    assign b_p   = v_reg[WIDTH-1] ? a_p : v_reg;

    assign abs_lcm = acc_lcm_reg[WIDTH-1] ? (WIDTH'(0) - acc_lcm_reg) : acc_lcm_reg;
    assign abs_v   = v_reg[WIDTH-1] ? (WIDTH'(0) - v_reg) : v_reg;

    // product of |quotient| and |value| sits in {u_hi, u_lo}
    assign prod_neg = (acc_lcm_reg[WIDTH-1] ^ v_reg[WIDTH-1]) && (|{u_hi, u_lo});
    assign limit    = prod_neg ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
    assign prod_ovf = (|u_hi) || (u_lo > limit);
    assign prod_res = prod_neg ? (WIDTH'(0) - u_lo) : u_lo;

    always_comb begin
        state_next      = state_reg;
        acc_gcd_next    = acc_gcd_reg;
        acc_lcm_next    = acc_lcm_reg;
        at_first_next   = at_first_reg;
        sticky_zd_next  = sticky_zd_reg;
        sticky_ovf_next = sticky_ovf_reg;
        v_next          = v_reg;
        last_next       = last_reg;
        phase_next      = phase_reg;
        ga_next         = ga_reg;
        gb_next         = gb_reg;
        cmd             = '{start: 1'b0, op: OP_DIV};
        op_a            = '0;
        op_b            = '0;
        out_load        = 1'b0;
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (at_first_reg) begin
                        acc_gcd_next  = v_in;
                        acc_lcm_next  = v_in;
                        at_first_next = 1'b0;
                        if (s_tlast) begin
                            state_next = ST_RESULT;
                        end
                    end else begin
                        v_next     = v_in;
                        last_next  = s_tlast;
                        phase_next = 1'b0;
                        state_next = ST_EUC_SETUP;
                    end
                end
            end
            ST_EUC_SETUP: begin
                // two negative operands give a gcd of zero
                if (a_p[WIDTH-1] || b_p[WIDTH-1]) begin
                    ga_next = '0;
                    gb_next = '0;
                end else begin
                    ga_next = a_p;
                    gb_next = b_p;
                end
                state_next = ST_EUC_TEST;
            end
            ST_EUC_TEST: begin
                if (gb_reg != '0) begin
                    cmd        = '{start: 1'b1, op: OP_DIV};
                    op_a       = ga_reg;
                    op_b       = gb_reg;
                    state_next = ST_EUC_WAIT;
                end else if (!phase_reg) begin
                    acc_gcd_next = ga_reg;
                    phase_next   = 1'b1;
                    state_next   = ST_EUC_SETUP;
                end else if (ga_reg == '0) begin
                    // zero divisor for the lcm step
                    sticky_zd_next = 1'b1;
                    acc_lcm_next   = '0;
                    state_next     = ST_END;
                end else begin
                    cmd        = '{start: 1'b1, op: OP_DIV};
                    op_a       = abs_lcm;
                    op_b       = ga_reg;
                    state_next = ST_QUO_WAIT;
                end
            end
            ST_EUC_WAIT: begin
                if (u_done) begin
                    ga_next    = gb_reg;
                    gb_next    = u_hi;
                    state_next = ST_EUC_TEST;
                end
            end
            ST_QUO_WAIT: begin
                if (u_done) begin
                    cmd        = '{start: 1'b1, op: OP_MUL};
                    op_a       = u_lo;
                    op_b       = abs_v;
                    state_next = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (u_done) begin
                    acc_lcm_next    = prod_res;
                    sticky_ovf_next = sticky_ovf_reg | prod_ovf;
                    state_next      = ST_END;
                end
            end
            ST_END: begin
                state_next = last_reg ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    out_load        = 1'b1;
                    at_first_next   = 1'b1;
                    sticky_zd_next  = 1'b0;
                    sticky_ovf_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = out_load | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_gcd_reg    <= '0;
            acc_lcm_reg    <= '0;
            at_first_reg   <= 1'b1;
            sticky_zd_reg  <= 1'b0;
            sticky_ovf_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acc_gcd_reg    <= acc_gcd_next;
            acc_lcm_reg    <= acc_lcm_next;
            at_first_reg   <= at_first_next;
            sticky_zd_reg  <= sticky_zd_next;
            sticky_ovf_reg <= sticky_ovf_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        last_reg  <= last_next;
        phase_reg <= phase_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        if (out_load) begin
            gcd_out_reg <= RES_W'(signed'(acc_gcd_reg));
            lcm_out_reg <= RES_W'(signed'(acc_lcm_reg));
            zd_out_reg  <= sticky_zd_reg;
            ovf_out_reg <= sticky_ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {lcm_out_reg, gcd_out_reg};
    assign m_tuser  = {ovf_out_reg, zd_out_reg};

    // a zero divisor pins the running lcm at zero
    a_zd_lcm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && zd_out_reg) |-> (lcm_out_reg == '0))
        else $error("zero divisor flagged with nonzero lcm");

    // while waiting on the unit it is running or just finished
    a_wait_unit_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EUC_WAIT || state_reg == ST_QUO_WAIT ||
         state_reg == ST_MUL_WAIT) |-> (u_done || $past(cmd.start) || u_unit.busy_reg))
        else $error("waiting on an idle unit");

    // a single-value list goes straight to the result
    a_single_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && at_first_reg && s_tlast) |=> (state_reg == ST_RESULT))
        else $error("single-value list did not report");

endmodule
